[rtl/core/gps_seconds_to_bcd_date_assert.svh]
// assertion macros shared by the date conversion pipeline
`ifndef GPS_SECONDS_TO_BCD_DATE_ASSERT_SVH
`define GPS_SECONDS_TO_BCD_DATE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GSBD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsbd: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define GSBD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsbd: next-cycle check failed");

`endif

[rtl/core/gsbd_pkg.sv]
// constants, tables, payload types and helpers of the date conversion pipeline
`timescale 1ns / 1ps

package gsbd_pkg;

    // time constants
    localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR     = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN      = 6'd60;
    localparam logic [2:0]  DAYS_BEFORE_EPOCH = 3'd5;
    localparam logic [10:0] DAYS_PER_CYCLE    = 11'd1461;

    // reciprocals floor(2^shift / divisor), estimate is low by at most one
    localparam logic [15:0] DAY_RECIP  = 16'd49710;
    localparam logic [5:0]  CYC_RECIP  = 6'd44;
    localparam logic [5:0]  HOUR_RECIP = 6'd36;
    localparam logic [6:0]  MIN_RECIP  = 7'd68;

    // cumulative day counts at the end of the first three years of a cycle
    localparam logic [10:0] YEAR1_END = 11'd366;
    localparam logic [10:0] YEAR2_END = 11'd731;
    localparam logic [10:0] YEAR3_END = 11'd1096;

    localparam logic [11:0] BASE_YEAR = 12'd1980;
    // only century year in the reachable range that is not a leap year
    localparam logic [11:0] COMMON_CENTURY = 12'd2100;

    localparam logic [4:0] ZONE_RESET = 5'd8;

    // days before the start of each month
    localparam logic [8:0] NORMAL_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [8:0] LEAP_BEFORE [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    typedef struct packed {
        logic [15:0] day_num;
        logic [16:0] sec_of_day;
    } t_split;

    typedef struct packed {
        logic [5:0]  cycle;
        logic [10:0] cycle_day;   // zero based
        logic [4:0]  hour;
        logic [11:0] sec_of_hour;
    } t_cycle;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } t_bcd2;

    typedef struct packed {
        logic [11:0] year_value;
        logic [0:0]  month_tens;
        logic [3:0]  month_ones;
        logic [1:0]  day_tens;
        logic [3:0]  day_ones;
        logic [1:0]  hour_tens;
        logic [3:0]  hour_ones;
        logic [2:0]  minute_tens;
        logic [3:0]  minute_ones;
        logic [2:0]  second_tens;
        logic [3:0]  second_ones;
    } t_date;

    // signed zone hours to seconds, two's complement in 32 bits
    function automatic logic [31:0] zone_secs(input logic [4:0] zone);
        logic signed [31:0] zs;
        zs = {{27{zone[4]}}, zone};
        return 32'(zs * 32'sd3600);
    endfunction

    // two decimal digits of a value below 100, tens by x*205 >> 11
    function automatic t_bcd2 split_digits(input logic [6:0] value);
        logic [14:0] prod;
        logic [6:0]  tens10;
        t_bcd2       res;
        prod     = 15'(value) * 15'd205;
        res.tens = prod[14:11];
        tens10   = 7'(res.tens) * 7'd10;
        res.ones = 4'(value - tens10);
        return res;
    endfunction

endpackage

[rtl/core/gsbd_split.sv]
// offset add and split of seconds into day number and second of day
`timescale 1ns / 1ps
`include "gps_seconds_to_bcd_date_assert.svh"

module gsbd_split (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_zone,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_secs,
    output logic               o_valid,
    input  logic               i_ready,
    output gsbd_pkg::t_split   o_data
);

    logic [3:0] r_v;
    logic [4:0] rdy;

    logic [31:0] r1_secs;
    logic [31:0] n1_secs;
    logic [47:0] n2_prod;
    logic [15:0] r2_est;
    logic [31:0] r2_secs;
    logic [32:0] n3_prod;
    logic [31:0] r3_prod;
    logic [15:0] r3_est;
    logic [31:0] r3_secs;
    logic [17:0] n4_rem;
    logic [15:0] n4_quot;
    gsbd_pkg::t_split n4_data;
    gsbd_pkg::t_split r4_data;

    // a stage moves when it is empty or the next one moves
    always_comb begin
        rdy[4] = i_ready;
        rdy[3] = !r_v[3] || rdy[4];
        rdy[2] = !r_v[2] || rdy[3];
        rdy[1] = !r_v[1] || rdy[2];
        rdy[0] = !r_v[0] || rdy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_comb begin
        n1_secs = i_secs + gsbd_pkg::zone_secs(i_zone);
        n2_prod = 48'(r1_secs) * 48'(gsbd_pkg::DAY_RECIP);
        n3_prod = 33'(r2_est) * 33'(gsbd_pkg::SECS_PER_DAY);
        n4_rem  = 18'(r3_secs - r3_prod);
        if (n4_rem >= 18'(gsbd_pkg::SECS_PER_DAY)) begin
            n4_quot            = r3_est + 16'd1;
            n4_data.sec_of_day = 17'(n4_rem - 18'(gsbd_pkg::SECS_PER_DAY));
        end else begin
            n4_quot            = r3_est;
            n4_data.sec_of_day = n4_rem[16:0];
        end
        n4_data.day_num = n4_quot + 16'(gsbd_pkg::DAYS_BEFORE_EPOCH);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r1_secs <= n1_secs;
        end
        if (rdy[1] && r_v[0]) begin
            r2_est  <= n2_prod[47:32];
            r2_secs <= r1_secs;
        end
        if (rdy[2] && r_v[1]) begin
            r3_prod <= n3_prod[31:0];
            r3_est  <= r2_est;
            r3_secs <= r2_secs;
        end
        if (rdy[3] && r_v[2]) begin
            r4_data <= n4_data;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[3];
    assign o_data  = r4_data;

    `GSBD_ASSERT_IMPL(a_sod_range, i_clk, i_rst_n, r_v[3], r4_data.sec_of_day < gsbd_pkg::SECS_PER_DAY)
    `GSBD_ASSERT_NEXT(a_split_hold, i_clk, i_rst_n, r_v[3] && !i_ready, r_v[3] && $stable(r4_data))

endmodule

[rtl/core/gsbd_cycle.sv]
// split of day number into four-year cycles and second of day into hours
`timescale 1ns / 1ps
`include "gps_seconds_to_bcd_date_assert.svh"

module gsbd_cycle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gsbd_pkg::t_split   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output gsbd_pkg::t_cycle   o_data
);

    logic [1:0] r_v;
    logic [2:0] rdy;

    logic [21:0] n5_cyc_prod;
    logic [21:0] n5_hr_prod;
    logic [5:0]  r5_est_cyc;
    logic [4:0]  r5_est_hr;
    logic [15:0] r5_day_num;
    logic [16:0] r5_sod;
    logic [15:0] n6_cyc_base;
    logic [11:0] n6_cyc_rem;
    logic [16:0] n6_hr_base;
    logic [12:0] n6_hr_rem;
    gsbd_pkg::t_cycle n6_data;
    gsbd_pkg::t_cycle r6_data;

    always_comb begin
        rdy[2] = i_ready;
        rdy[1] = !r_v[1] || rdy[2];
        rdy[0] = !r_v[0] || rdy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
        end
    end

    always_comb begin
        n5_cyc_prod = 22'(i_data.day_num) * 22'(gsbd_pkg::CYC_RECIP);
        n5_hr_prod  = 22'(i_data.sec_of_day) * 22'(gsbd_pkg::HOUR_RECIP);

        n6_cyc_base = 16'(r5_est_cyc) * 16'(gsbd_pkg::DAYS_PER_CYCLE);
        n6_cyc_rem  = 12'(r5_day_num - n6_cyc_base);
        if (n6_cyc_rem >= 12'(gsbd_pkg::DAYS_PER_CYCLE)) begin
            n6_data.cycle     = r5_est_cyc + 6'd1;
            n6_data.cycle_day = 11'(n6_cyc_rem - 12'(gsbd_pkg::DAYS_PER_CYCLE));
        end else begin
            n6_data.cycle     = r5_est_cyc;
            n6_data.cycle_day = n6_cyc_rem[10:0];
        end

        n6_hr_base = 17'(r5_est_hr) * 17'(gsbd_pkg::SECS_PER_HOUR);
        n6_hr_rem  = 13'(r5_sod - n6_hr_base);
        if (n6_hr_rem >= 13'(gsbd_pkg::SECS_PER_HOUR)) begin
            n6_data.hour        = r5_est_hr + 5'd1;
            n6_data.sec_of_hour = 12'(n6_hr_rem - 13'(gsbd_pkg::SECS_PER_HOUR));
        end else begin
            n6_data.hour        = r5_est_hr;
            n6_data.sec_of_hour = n6_hr_rem[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r5_est_cyc <= n5_cyc_prod[21:16];
            r5_est_hr  <= n5_hr_prod[21:17];
            r5_day_num <= i_data.day_num;
            r5_sod     <= i_data.sec_of_day;
        end
        if (rdy[1] && r_v[0]) begin
            r6_data <= n6_data;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[1];
    assign o_data  = r6_data;

    `GSBD_ASSERT_IMPL(a_cycle_range, i_clk, i_rst_n, r_v[1], (r6_data.cycle_day < gsbd_pkg::DAYS_PER_CYCLE) && (r6_data.sec_of_hour < gsbd_pkg::SECS_PER_HOUR) && (r6_data.hour < 5'd24))

endmodule

[rtl/core/gsbd_calendar.sv]
// year and month walk, minute split and decimal digits of the result
`timescale 1ns / 1ps
`include "gps_seconds_to_bcd_date_assert.svh"

module gsbd_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gsbd_pkg::t_cycle   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output gsbd_pkg::t_date    o_data
);

    logic [2:0] r_v;
    logic [3:0] rdy;

    // stage 7
    logic [10:0] n7_doc;
    logic [1:0]  n7_yi;
    logic [8:0]  n7_diy;
    logic [11:0] n7_year;
    logic [17:0] n7_min_prod;
    logic [11:0] r7_year;
    logic        r7_leap;
    logic [8:0]  r7_diy;
    logic [5:0]  r7_est_min;
    logic [11:0] r7_soh;
    gsbd_pkg::t_bcd2 r7_hour;
    // stage 8
    logic [3:0]  n8_midx;
    logic [11:0] n8_min_base;
    logic [6:0]  n8_min_rem;
    logic [5:0]  n8_minute;
    logic [5:0]  n8_second;
    logic [11:0] r8_year;
    logic        r8_leap;
    logic [8:0]  r8_diy;
    logic [3:0]  r8_midx;
    logic [5:0]  r8_minute;
    logic [5:0]  r8_second;
    gsbd_pkg::t_bcd2 r8_hour;
    // stage 9
    logic [8:0]  n9_before;
    logic [5:0]  n9_day;
    logic [3:0]  n9_month;
    gsbd_pkg::t_bcd2 n9_day_bcd;
    gsbd_pkg::t_bcd2 n9_min_bcd;
    gsbd_pkg::t_bcd2 n9_sec_bcd;
    gsbd_pkg::t_date n9_data;
    gsbd_pkg::t_date r9_data;
    // output digit checks
    logic        month_ok;
    logic        time_ok;

    always_comb begin
        rdy[3] = i_ready;
        rdy[2] = !r_v[2] || rdy[3];
        rdy[1] = !r_v[1] || rdy[2];
        rdy[0] = !r_v[0] || rdy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
        end
    end

    // year within the cycle, first year of each cycle gets 366 days
    always_comb begin
        n7_doc = i_data.cycle_day + 11'd1;
        if (n7_doc > gsbd_pkg::YEAR3_END) begin
            n7_yi  = 2'd3;
            n7_diy = 9'(n7_doc - gsbd_pkg::YEAR3_END);
        end else if (n7_doc > gsbd_pkg::YEAR2_END) begin
            n7_yi  = 2'd2;
            n7_diy = 9'(n7_doc - gsbd_pkg::YEAR2_END);
        end else if (n7_doc > gsbd_pkg::YEAR1_END) begin
            n7_yi  = 2'd1;
            n7_diy = 9'(n7_doc - gsbd_pkg::YEAR1_END);
        end else begin
            n7_yi  = 2'd0;
            n7_diy = n7_doc[8:0];
        end
        n7_year     = gsbd_pkg::BASE_YEAR + 12'({i_data.cycle, 2'b00}) + 12'(n7_yi);
        n7_min_prod = 18'(i_data.sec_of_hour) * 18'(gsbd_pkg::MIN_RECIP);
    end

    // month index counts month ends passed, table rises so this matches the walk
    always_comb begin
        n8_midx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r7_leap) begin
                if (r7_diy > gsbd_pkg::LEAP_BEFORE[4'(i)]) n8_midx = n8_midx + 4'd1;
            end else begin
                if (r7_diy > gsbd_pkg::NORMAL_BEFORE[4'(i)]) n8_midx = n8_midx + 4'd1;
            end
        end
        n8_min_base = 12'(r7_est_min) * 12'(gsbd_pkg::SECS_PER_MIN);
        n8_min_rem  = 7'(r7_soh - n8_min_base);
        if (n8_min_rem >= 7'(gsbd_pkg::SECS_PER_MIN)) begin
            n8_minute = r7_est_min + 6'd1;
            n8_second = 6'(n8_min_rem - 7'(gsbd_pkg::SECS_PER_MIN));
        end else begin
            n8_minute = r7_est_min;
            n8_second = n8_min_rem[5:0];
        end
    end

    // day 366 of a common year lands in december as day 32
    always_comb begin
        n9_before  = r8_leap ? gsbd_pkg::LEAP_BEFORE[r8_midx] : gsbd_pkg::NORMAL_BEFORE[r8_midx];
        n9_day     = 6'(r8_diy - n9_before);
        n9_month   = r8_midx + 4'd1;
        n9_day_bcd = gsbd_pkg::split_digits(7'(n9_day));
        n9_min_bcd = gsbd_pkg::split_digits(7'(r8_minute));
        n9_sec_bcd = gsbd_pkg::split_digits(7'(r8_second));

        n9_data.year_value  = r8_year;
        n9_data.month_tens  = (n9_month >= 4'd10);
        n9_data.month_ones  = (n9_month >= 4'd10) ? (n9_month - 4'd10) : n9_month;
        n9_data.day_tens    = 2'(n9_day_bcd.tens);
        n9_data.day_ones    = n9_day_bcd.ones;
        n9_data.hour_tens   = 2'(r8_hour.tens);
        n9_data.hour_ones   = r8_hour.ones;
        n9_data.minute_tens = 3'(n9_min_bcd.tens);
        n9_data.minute_ones = n9_min_bcd.ones;
        n9_data.second_tens = 3'(n9_sec_bcd.tens);
        n9_data.second_ones = n9_sec_bcd.ones;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r7_year    <= n7_year;
            r7_leap    <= (n7_yi == 2'd0) && (n7_year != gsbd_pkg::COMMON_CENTURY);
            r7_diy     <= n7_diy;
            r7_est_min <= n7_min_prod[17:12];
            r7_soh     <= i_data.sec_of_hour;
            r7_hour    <= gsbd_pkg::split_digits(7'(i_data.hour));
        end
        if (rdy[1] && r_v[0]) begin
            r8_year   <= r7_year;
            r8_leap   <= r7_leap;
            r8_diy    <= r7_diy;
            r8_midx   <= n8_midx;
            r8_minute <= n8_minute;
            r8_second <= n8_second;
            r8_hour   <= r7_hour;
        end
        if (rdy[2] && r_v[1]) begin
            r9_data <= n9_data;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[2];
    assign o_data  = r9_data;

    // month 1 to 12, minute and second digits in range
    assign month_ok = (r9_data.month_tens == 1'b0) ? (r9_data.month_ones != 4'd0)
                                                   : (r9_data.month_ones <= 4'd2);
    assign time_ok  = (r9_data.minute_tens <= 3'd5) && (r9_data.second_tens <= 3'd5)
                   && (r9_data.minute_ones <= 4'd9) && (r9_data.second_ones <= 4'd9);

    `GSBD_ASSERT_IMPL(a_month_digits, i_clk, i_rst_n, r_v[2], month_ok)
    `GSBD_ASSERT_IMPL(a_time_digits, i_clk, i_rst_n, r_v[2], time_ok)

endmodule

[rtl/core/gps_seconds_to_bcd_date.sv]
// top level: seconds since the 1980-01-06 epoch to calendar date and time digits
//
//   channel   direction   handshake             payload
//   cfg       in          i_cfg_valid/o_cfg_ready  i_cfg_data (zone offset hours, signed)
//   in        in          i_in_valid/o_in_stall    i_epoch_seconds
//   out       out         o_out_valid/i_out_stall  o_year_value .. o_second_ones
//
// one request per cycle sustained while i_out_stall stays low; a result passes through
// the nine register stages of reciprocal divides and table walks
// synchronous active-low reset empties all stages and sets the zone offset to +8
// a stall on the output holds the last stage; stages behind it keep filling
// bubbles, and o_in_stall rises only when every stage holds a request
`timescale 1ns / 1ps

module gps_seconds_to_bcd_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    // request side
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_epoch_seconds,
    // result side
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_year_value,
    output logic [0:0]  o_month_tens,
    output logic [3:0]  o_month_ones,
    output logic [1:0]  o_day_tens,
    output logic [3:0]  o_day_ones,
    output logic [1:0]  o_hour_tens,
    output logic [3:0]  o_hour_ones,
    output logic [2:0]  o_minute_tens,
    output logic [3:0]  o_minute_ones,
    output logic [2:0]  o_second_tens,
    output logic [3:0]  o_second_ones
);

    // zone offset register, applied in the first stage
    logic [4:0] r_zone;

    logic             split_ready;
    logic             split_valid;
    gsbd_pkg::t_split split_data;
    logic             cycle_ready;
    logic             cycle_valid;
    gsbd_pkg::t_cycle cycle_data;
    logic             cal_ready;
    gsbd_pkg::t_date  cal_data;

    // writes are always taken; only written while the pipe is empty, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= gsbd_pkg::ZONE_RESET;
        end else if (i_cfg_valid) begin
            r_zone <= i_cfg_data;
        end
    end

    // stages 1-4: add offset, seconds to day number and second of day
    gsbd_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_zone  (r_zone),
        .i_valid (i_in_valid),
        .o_ready (split_ready),
        .i_secs  (i_epoch_seconds),
        .o_valid (split_valid),
        .i_ready (cycle_ready),
        .o_data  (split_data)
    );

    // stages 5-6: four-year cycle and hour split
    gsbd_cycle u_cycle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (cycle_ready),
        .i_data  (split_data),
        .o_valid (cycle_valid),
        .i_ready (cal_ready),
        .o_data  (cycle_data)
    );

    // stages 7-9: year and month walk, minute split, decimal digits
    gsbd_calendar u_calendar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cycle_valid),
        .o_ready (cal_ready),
        .i_data  (cycle_data),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_data  (cal_data)
    );

    assign o_in_stall = !split_ready;

    // result fields straight from the output register
    assign o_year_value  = cal_data.year_value;
    assign o_month_tens  = cal_data.month_tens;
    assign o_month_ones  = cal_data.month_ones;
    assign o_day_tens    = cal_data.day_tens;
    assign o_day_ones    = cal_data.day_ones;
    assign o_hour_tens   = cal_data.hour_tens;
    assign o_hour_ones   = cal_data.hour_ones;
    assign o_minute_tens = cal_data.minute_tens;
    assign o_minute_ones = cal_data.minute_ones;
    assign o_second_tens = cal_data.second_tens;
    assign o_second_ones = cal_data.second_ones;

endmodule
